// ===== rtl/core/blr_pkg.sv =====
// Shared constants and types for the Bresenham line rasterizer.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package blr_pkg;

   // Raster size in pixels
   localparam int RASTER_WIDTH  = 128;
   localparam int RASTER_HEIGHT = 64;

   // Port widths of the coordinate fields
   localparam int X_W = 7;
   localparam int Y_W = 6;

   // Internal coordinate width: wide enough for either axis
   localparam int C_W = (X_W > Y_W) ? X_W : Y_W;

   // Signed error accumulator width
   localparam int E_W = C_W + 2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_INIT,
      ST_WALK
   } state_type;

endpackage

// ===== rtl/core/bresenham_line_rasterizer.sv =====
// Sequencing: an item is accepted in idle, then passes through the setup and init states; the walk
// then steps one pixel per cycle unless a stalled result holds it, registering each pixel pair.
// A line stalls the input until its last pixel is walked, so no new item is taken while one is in
// flight; the pace is set by the single error-update step, one pixel per cycle while the output is free.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
// Depends on blr_pkg.
module bresenham_line_rasterizer
   import blr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [X_W-1:0] req_start_x,
   input  logic [Y_W-1:0] req_start_y,
   input  logic [X_W-1:0] req_end_x,
   input  logic [Y_W-1:0] req_end_y,
   input  logic           req_erase_mode,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [X_W-1:0] rsp_pixel_a_x,
   output logic [Y_W-1:0] rsp_pixel_a_y,
   output logic [X_W-1:0] rsp_pixel_b_x,
   output logic [Y_W-1:0] rsp_pixel_b_y,
   output logic           rsp_pixel_b_valid,
   output logic           rsp_pixel_clear,
   output logic           rsp_last_of_line
);

   localparam logic [C_W-1:0] X_MAX = C_W'(RASTER_WIDTH - 1);
   localparam logic [C_W-1:0] Y_MAX = C_W'(RASTER_HEIGHT - 1);

   state_type state_ff, state_in;

   logic [C_W-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic           clr_ff, clr_in;
   logic           swap_ff, swap_in;
   logic           step_neg_ff, step_neg_in;
   logic [C_W-1:0] mj_ff, mj_in, mn_ff, mn_in, maj_end_ff, maj_end_in;
   logic [C_W-1:0] dmaj_ff, dmaj_in, dmin_ff, dmin_in, diff_ff, diff_in;
   logic signed [E_W-1:0] err_ff, err_in;
   logic           have_a_ff, have_a_in;
   logic [C_W-1:0] buf_x_ff, buf_x_in, buf_y_ff, buf_y_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [X_W-1:0] rsp_a_x_ff, rsp_a_x_in, rsp_b_x_ff, rsp_b_x_in;
   logic [Y_W-1:0] rsp_a_y_ff, rsp_a_y_in, rsp_b_y_ff, rsp_b_y_in;
   logic           rsp_b_valid_ff, rsp_b_valid_in;
   logic           rsp_clear_ff, rsp_clear_in;
   logic           rsp_last_ff, rsp_last_in;

   // Clamped endpoints at the input
   logic [C_W-1:0] in_ax, in_ay, in_bx, in_by;

   // Setup terms
   logic [C_W-1:0] span_x, span_y;
   logic           swap_c;
   logic [C_W-1:0] maj0, min0, maj1, min1;

   // Walk terms
   logic [C_W-1:0] px, py;
   logic           last_px, emit, out_free, advance;
   logic signed [E_W-1:0] err_sub, err_add;

   // Saturate off-raster endpoints to the edge
   always_comb begin
      in_ax = (C_W'(req_start_x) > X_MAX) ? X_MAX : C_W'(req_start_x);
      in_ay = (C_W'(req_start_y) > Y_MAX) ? Y_MAX : C_W'(req_start_y);
      in_bx = (C_W'(req_end_x) > X_MAX) ? X_MAX : C_W'(req_end_x);
      in_by = (C_W'(req_end_y) > Y_MAX) ? Y_MAX : C_W'(req_end_y);
   end

   // Pick the major axis and order the endpoints so the major coordinate rises
   always_comb begin
      span_x = (ax_ff > bx_ff) ? (ax_ff - bx_ff) : (bx_ff - ax_ff);
      span_y = (ay_ff > by_ff) ? (ay_ff - by_ff) : (by_ff - ay_ff);
      swap_c = (span_y > span_x);
      if (swap_c) begin
         maj0 = ay_ff;
         min0 = ax_ff;
         maj1 = by_ff;
         min1 = bx_ff;
      end else begin
         maj0 = ax_ff;
         min0 = ay_ff;
         maj1 = bx_ff;
         min1 = by_ff;
      end
      if (maj0 > maj1) begin
         {maj0, maj1} = {maj1, maj0};
         {min0, min1} = {min1, min0};
      end
   end

   // Current pixel and the shared error update
   always_comb begin
      px       = swap_ff ? mn_ff : mj_ff;
      py       = swap_ff ? mj_ff : mn_ff;
      last_px  = (mj_ff == maj_end_ff);
      emit     = have_a_ff || last_px;
      out_free = !rsp_valid_ff || !rsp_stall;
      advance  = (state_ff == ST_WALK) && (!emit || out_free);
      err_sub  = err_ff - $signed({2'b00, dmin_ff});
      err_add  = err_ff + $signed({2'b00, diff_ff});
   end

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      bx_in          = bx_ff;
      by_in          = by_ff;
      clr_in         = clr_ff;
      swap_in        = swap_ff;
      step_neg_in    = step_neg_ff;
      mj_in          = mj_ff;
      mn_in          = mn_ff;
      maj_end_in     = maj_end_ff;
      dmaj_in        = dmaj_ff;
      dmin_in        = dmin_ff;
      diff_in        = diff_ff;
      err_in         = err_ff;
      have_a_in      = have_a_ff;
      buf_x_in       = buf_x_ff;
      buf_y_in       = buf_y_ff;
      rsp_a_x_in     = rsp_a_x_ff;
      rsp_a_y_in     = rsp_a_y_ff;
      rsp_b_x_in     = rsp_b_x_ff;
      rsp_b_y_in     = rsp_b_y_ff;
      rsp_b_valid_in = rsp_b_valid_ff;
      rsp_clear_in   = rsp_clear_ff;
      rsp_last_in    = rsp_last_ff;

      // Drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in    = in_ax;
               ay_in    = in_ay;
               bx_in    = in_bx;
               by_in    = in_by;
               clr_in   = req_erase_mode;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            swap_in     = swap_c;
            mj_in       = maj0;
            mn_in       = min0;
            maj_end_in  = maj1;
            dmaj_in     = swap_c ? span_y : span_x;
            dmin_in     = swap_c ? span_x : span_y;
            step_neg_in = !(min1 > min0);
            have_a_in   = 1'b0;
            state_in    = ST_INIT;
         end
         ST_INIT: begin
            err_in   = $signed({3'b000, dmaj_ff[C_W-1:1]});
            diff_in  = dmaj_ff - dmin_ff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (advance) begin
               // Pair up pixels; flush a lone last pixel with b invalid
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_clear_in = clr_ff;
                  rsp_last_in  = last_px;
                  have_a_in    = 1'b0;
                  if (have_a_ff) begin
                     rsp_a_x_in     = buf_x_ff[X_W-1:0];
                     rsp_a_y_in     = buf_y_ff[Y_W-1:0];
                     rsp_b_x_in     = px[X_W-1:0];
                     rsp_b_y_in     = py[Y_W-1:0];
                     rsp_b_valid_in = 1'b1;
                  end else begin
                     rsp_a_x_in     = px[X_W-1:0];
                     rsp_a_y_in     = py[Y_W-1:0];
                     rsp_b_x_in     = '0;
                     rsp_b_y_in     = '0;
                     rsp_b_valid_in = 1'b0;
                  end
               end else begin
                  buf_x_in  = px;
                  buf_y_in  = py;
                  have_a_in = 1'b1;
               end
               // Advance the walk one pixel
               mj_in = mj_ff + C_W'(1);
               if (err_sub < 0) begin
                  err_in = err_add;
                  mn_in  = step_neg_ff ? (mn_ff - C_W'(1)) : (mn_ff + C_W'(1));
               end else begin
                  err_in = err_sub;
               end
               if (last_px) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_a_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_a_ff    <= have_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      bx_ff          <= bx_in;
      by_ff          <= by_in;
      clr_ff         <= clr_in;
      swap_ff        <= swap_in;
      step_neg_ff    <= step_neg_in;
      mj_ff          <= mj_in;
      mn_ff          <= mn_in;
      maj_end_ff     <= maj_end_in;
      dmaj_ff        <= dmaj_in;
      dmin_ff        <= dmin_in;
      diff_ff        <= diff_in;
      err_ff         <= err_in;
      buf_x_ff       <= buf_x_in;
      buf_y_ff       <= buf_y_in;
      rsp_a_x_ff     <= rsp_a_x_in;
      rsp_a_y_ff     <= rsp_a_y_in;
      rsp_b_x_ff     <= rsp_b_x_in;
      rsp_b_y_ff     <= rsp_b_y_in;
      rsp_b_valid_ff <= rsp_b_valid_in;
      rsp_clear_ff   <= rsp_clear_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_a_x     = rsp_a_x_ff;
   assign rsp_pixel_a_y     = rsp_a_y_ff;
   assign rsp_pixel_b_x     = rsp_b_x_ff;
   assign rsp_pixel_b_y     = rsp_b_y_ff;
   assign rsp_pixel_b_valid = rsp_b_valid_ff;
   assign rsp_pixel_clear   = rsp_clear_ff;
   assign rsp_last_of_line  = rsp_last_ff;

endmodule

// ===== rtl/core/blr_checker.sv =====
// Port-level checker for the Bresenham line rasterizer, bound to the top level.
// Depends on blr_pkg for the field widths.
module blr_checker
   import blr_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input logic [X_W-1:0] rsp_pixel_a_x,
   input logic [Y_W-1:0] rsp_pixel_a_y,
   input logic [X_W-1:0] rsp_pixel_b_x,
   input logic [Y_W-1:0] rsp_pixel_b_y,
   input logic           rsp_pixel_b_valid,
   input logic           rsp_last_of_line
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_a_x) && $stable(rsp_pixel_a_y)
         && $stable(rsp_last_of_line))
      else $error("stalled result changed");

   // Busy right after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second item during setup");

   // A lone pixel only closes a line, with zeroed b coordinates
   a_lone_pixel_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_b_valid |-> rsp_last_of_line && rsp_pixel_b_x == '0
         && rsp_pixel_b_y == '0)
      else $error("unpaired pixel not at end of line");

   // Paired pixels are neighbors
   a_pair_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_b_valid |->
         ((rsp_pixel_a_x >= rsp_pixel_b_x) ? (rsp_pixel_a_x - rsp_pixel_b_x)
                                           : (rsp_pixel_b_x - rsp_pixel_a_x)) <= X_W'(1)
         && ((rsp_pixel_a_y >= rsp_pixel_b_y) ? (rsp_pixel_a_y - rsp_pixel_b_y)
                                              : (rsp_pixel_b_y - rsp_pixel_a_y)) <= Y_W'(1))
      else $error("pixel pair not adjacent");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_a_x     (rsp_pixel_a_x),
   .rsp_pixel_a_y     (rsp_pixel_a_y),
   .rsp_pixel_b_x     (rsp_pixel_b_x),
   .rsp_pixel_b_y     (rsp_pixel_b_y),
   .rsp_pixel_b_valid (rsp_pixel_b_valid),
   .rsp_last_of_line  (rsp_last_of_line)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the Bresenham line rasterizer: a directed table, then random lines
// under three idle profiles, each pair checked against a local line walker or a typed-in result.
// Depends on blr_pkg and the bresenham_line_rasterizer top level.
module tb
   import blr_pkg::*;
();

   // One result of the block: a pair of pixels plus its flags
   typedef struct packed {
      logic [X_W-1:0] a_x;
      logic [Y_W-1:0] a_y;
      logic [X_W-1:0] b_x;
      logic [Y_W-1:0] b_y;
      logic           b_valid;
      logic           clear;
      logic           last;
   } pixel_pair_type;

   // One directed line; the g_ fields hold a typed-in single result where golden is set
   typedef struct packed {
      logic [X_W-1:0] sx;
      logic [Y_W-1:0] sy;
      logic [X_W-1:0] ex;
      logic [Y_W-1:0] ey;
      logic           erase;
      logic           golden;
      logic [X_W-1:0] g_ax;
      logic [Y_W-1:0] g_ay;
      logic [X_W-1:0] g_bx;
      logic [Y_W-1:0] g_by;
      logic           g_bv;
   } line_row_type;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_PER_PHASE = 49;
   localparam int DRAIN_CYCLES = 20;

   // Directed lines: single points, extremes, both orders, steep, shallow, equal spans
   line_row_type directed_rows [DIRECTED_COUNT] = '{
      '{0,   0,  0,   0,  0, 1, 0,   0,  0, 0, 0},
      '{127, 63, 127, 63, 1, 1, 127, 63, 0, 0, 0},
      '{127, 0,  127, 0,  0, 1, 127, 0,  0, 0, 0},
      '{0,   63, 0,   63, 1, 1, 0,   63, 0, 0, 0},
      '{64,  32, 64,  32, 1, 1, 64,  32, 0, 0, 0},
      '{0,   0,  1,   0,  0, 1, 0,   0,  1, 0, 1},
      '{1,   0,  0,   0,  1, 1, 0,   0,  1, 0, 1},
      '{0,   0,  0,   1,  0, 1, 0,   0,  0, 1, 1},
      '{0,   0,  2,   0,  0, 0, 0,   0,  0, 0, 0},
      '{0,   0,  127, 0,  0, 0, 0,   0,  0, 0, 0},
      '{0,   0,  0,   63, 1, 0, 0,   0,  0, 0, 0},
      '{5,   63, 5,   0,  1, 0, 0,   0,  0, 0, 0},
      '{0,   0,  127, 63, 0, 0, 0,   0,  0, 0, 0},
      '{127, 63, 0,   0,  1, 0, 0,   0,  0, 0, 0},
      '{0,   63, 127, 0,  0, 0, 0,   0,  0, 0, 0},
      '{127, 0,  0,   63, 1, 0, 0,   0,  0, 0, 0},
      '{10,  10, 20,  20, 0, 0, 0,   0,  0, 0, 0},
      '{20,  20, 10,  30, 1, 0, 0,   0,  0, 0, 0},
      '{3,   7,  60,  9,  0, 0, 0,   0,  0, 0, 0},
      '{60,  9,  3,   7,  1, 0, 0,   0,  0, 0, 0},
      '{40,  2,  45,  60, 0, 0, 0,   0,  0, 0, 0},
      '{45,  60, 40,  2,  1, 0, 0,   0,  0, 0, 0}
   };

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   logic [X_W-1:0] req_start_x;
   logic [Y_W-1:0] req_start_y;
   logic [X_W-1:0] req_end_x;
   logic [Y_W-1:0] req_end_y;
   logic           req_erase_mode;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [X_W-1:0] rsp_pixel_a_x;
   logic [Y_W-1:0] rsp_pixel_a_y;
   logic [X_W-1:0] rsp_pixel_b_x;
   logic [Y_W-1:0] rsp_pixel_b_y;
   logic           rsp_pixel_b_valid;
   logic           rsp_pixel_clear;
   logic           rsp_last_of_line;

   pixel_pair_type expected_pairs [$];
   pixel_pair_type oldest_pair;
   int          send_idle_pct = 9;
   int          rsp_stall_pct = 56;
   int          error_count = 0;
   int          lines_sent = 0;
   int          pairs_checked = 0;

   bresenham_line_rasterizer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_erase_mode    (req_erase_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_a_x     (rsp_pixel_a_x),
      .rsp_pixel_a_y     (rsp_pixel_a_y),
      .rsp_pixel_b_x     (rsp_pixel_b_x),
      .rsp_pixel_b_y     (rsp_pixel_b_y),
      .rsp_pixel_b_valid (rsp_pixel_b_valid),
      .rsp_pixel_clear   (rsp_pixel_clear),
      .rsp_last_of_line  (rsp_last_of_line)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clip a coordinate into 0..hi
   function automatic int saturate(input int v, input int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // Walk one line and queue its pixel pairs in output order
   function automatic void rasterize_line(input int sx, input int sy, input int ex,
                                          input int ey, input bit erase);
      int ax, ay, bx, by, span_x, span_y;
      int maj0, min0, maj1, min1, dmaj, dmin, err, stp, mn, mj, px, py, t, pix_count;
      bit swap_axes;
      pixel_pair_type pair;
      ax = saturate(sx, RASTER_WIDTH - 1);
      ay = saturate(sy, RASTER_HEIGHT - 1);
      bx = saturate(ex, RASTER_WIDTH - 1);
      by = saturate(ey, RASTER_HEIGHT - 1);
      span_x = (ax > bx) ? ax - bx : bx - ax;
      span_y = (ay > by) ? ay - by : by - ay;
      // walk along y when the line is steep; ties stay on x
      swap_axes = span_y > span_x;
      if (swap_axes) begin
         maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
         dmaj = span_y; dmin = span_x;
      end else begin
         maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
         dmaj = span_x; dmin = span_y;
      end
      // order endpoints so the major coordinate rises
      if (maj0 > maj1) begin
         t = maj0; maj0 = maj1; maj1 = t;
         t = min0; min0 = min1; min1 = t;
      end
      err = dmaj / 2;
      stp = (min1 > min0) ? 1 : -1;
      mn = min0;
      pix_count = 0;
      pair = '0;
      for (mj = maj0; mj <= maj1; mj++) begin
         px = swap_axes ? mn : mj;
         py = swap_axes ? mj : mn;
         if (pix_count % 2 == 0) begin
            pair = '0;
            pair.a_x = px[X_W-1:0];
            pair.a_y = py[Y_W-1:0];
            pair.clear = erase;
         end else begin
            pair.b_x = px[X_W-1:0];
            pair.b_y = py[Y_W-1:0];
            pair.b_valid = 1'b1;
            expected_pairs.push_back(pair);
         end
         pix_count++;
         err -= dmin;
         if (err < 0) begin
            mn += stp;
            err += dmaj;
         end
      end
      // flush an unpaired final pixel, then mark the end of the line
      if (pix_count % 2 != 0) expected_pairs.push_back(pair);
      expected_pairs[expected_pairs.size() - 1].last = 1'b1;
   endfunction

   // Offer one line, wait until the input stall drops, then queue what it must produce
   task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                            input bit erase, input bit golden, input pixel_pair_type gold);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_start_x    <= sx[X_W-1:0];
      req_start_y    <= sy[Y_W-1:0];
      req_end_x      <= ex[X_W-1:0];
      req_end_y      <= ey[Y_W-1:0];
      req_erase_mode <= erase;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (golden) expected_pairs.push_back(gold);
      else rasterize_line(sx, sy, ex, ey, erase);
      lines_sent++;
   endtask

   // Pick a random line shape: mostly long and short lines, some axis, diagonal and point
   task automatic random_line();
      int shape, sx, sy, ex, ey, d, t;
      bit erase;
      shape = $urandom_range(0, 9);
      erase = $urandom_range(0, 1);
      sx = $urandom_range(0, RASTER_WIDTH - 1);
      sy = $urandom_range(0, RASTER_HEIGHT - 1);
      ex = $urandom_range(0, RASTER_WIDTH - 1);
      ey = $urandom_range(0, RASTER_HEIGHT - 1);
      if (shape >= 4 && shape <= 6) begin
         ex = saturate(sx + $urandom_range(0, 16) - 8, RASTER_WIDTH - 1);
         ey = saturate(sy + $urandom_range(0, 16) - 8, RASTER_HEIGHT - 1);
      end else if (shape == 7) begin
         if ($urandom_range(0, 1)) ey = sy;
         else ex = sx;
      end else if (shape == 8) begin
         d = $urandom_range(0, RASTER_HEIGHT / 2 - 1);
         sx = $urandom_range(0, RASTER_WIDTH - 1 - d);
         sy = $urandom_range(0, RASTER_HEIGHT - 1 - d);
         ex = sx + d;
         ey = sy + d;
         if ($urandom_range(0, 1)) begin
            t = sy; sy = ey; ey = t;
         end
         if ($urandom_range(0, 1)) begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
         end
      end else if (shape == 9) begin
         ex = sx;
         ey = sy;
      end
      send_line(sx, sy, ex, ey, erase, 1'b0, '0);
   endtask

   // Compare one result field and count a mismatch
   function automatic void check_field(input string field_name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field_name, want, got);
         error_count++;
      end
   endfunction

   // Randomize the result stall every cycle
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Check each accepted result against the oldest expected pair
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            $error("unexpected result: pixel_a_x %0d pixel_a_y %0d", rsp_pixel_a_x,
                   rsp_pixel_a_y);
            error_count++;
         end else begin
            oldest_pair = expected_pairs.pop_front();
            check_field("pixel_a_x", oldest_pair.a_x, rsp_pixel_a_x);
            check_field("pixel_a_y", oldest_pair.a_y, rsp_pixel_a_y);
            check_field("pixel_b_x", oldest_pair.b_x, rsp_pixel_b_x);
            check_field("pixel_b_y", oldest_pair.b_y, rsp_pixel_b_y);
            check_field("pixel_b_valid", oldest_pair.b_valid, rsp_pixel_b_valid);
            check_field("pixel_clear", oldest_pair.clear, rsp_pixel_clear);
            check_field("last_of_line", oldest_pair.last, rsp_last_of_line);
            pairs_checked++;
         end
      end
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Reset, then the directed table and random lines under three idle profiles
   initial begin
      pixel_pair_type gold;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_x    = '0;
      req_start_y    = '0;
      req_end_x      = '0;
      req_end_y      = '0;
      req_erase_mode = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 9;  rsp_stall_pct = 56; end
            1: begin send_idle_pct = 56; rsp_stall_pct = 9;  end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         if (phase == 0) begin
            for (int i = 0; i < DIRECTED_COUNT; i++) begin
               gold = '{directed_rows[i].g_ax, directed_rows[i].g_ay, directed_rows[i].g_bx,
                        directed_rows[i].g_by, directed_rows[i].g_bv,
                        directed_rows[i].erase, 1'b1};
               send_line(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].ex,
                         directed_rows[i].ey, directed_rows[i].erase,
                         directed_rows[i].golden, gold);
            end
         end
         for (int i = 0; i < RANDOM_PER_PHASE; i++) random_line();
      end
      req_valid <= 1'b0;

      // Drain outstanding pairs, then watch for strays
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drew %0d lines and checked %0d pixel pairs over three idle profiles.",
               lines_sent, pairs_checked);
      $display("Mismatches and stray results: %0d", error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
